// ===== rtl/ldh_pkg.sv =====
// Shared types, constants and the divide-by-25 step of the loop duration histogram.
package ldh_pkg;

  // Histogram geometry.
  localparam int unsigned NUM_BUCKETS    = 16;
  localparam int unsigned BKT_W          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned US_PER_BUCKET  = 100;
  localparam int unsigned BKT_SPAN       = NUM_BUCKETS * US_PER_BUCKET;
  localparam int unsigned SPAN_W         = $clog2(BKT_SPAN);

  // Bucket index by reciprocal: x * 655 >> 16 is floor(x / 100) or one less.
  localparam int unsigned RECIP100       = 655;
  localparam int unsigned RECIP100_SHIFT = 16;
  localparam int unsigned XP_W           = SPAN_W + 10;

  // Ticks to microseconds: 200 = 8 * 25, a shift and then a division by 25.
  localparam int unsigned TICK_SHIFT     = 3;
  localparam int unsigned TICK_ODD       = 25;
  localparam int unsigned RECIP25        = 1310;
  localparam int unsigned RECIP25_SHIFT  = 15;
  localparam int unsigned DIV_STAGES     = 8;

  // Microseconds to rounded milliseconds: (d + 500) / 1000 = ((d + 500) >> 3) / 125.
  localparam int unsigned HALF_MS_US     = 500;
  localparam int unsigned MS_SHIFT       = 3;
  localparam int unsigned MS_ODD         = 125;
  localparam longint unsigned RECIP125   = 64'd1099511627;
  localparam int unsigned RECIP125_SHIFT = 37;
  localparam int unsigned Y_W            = 30;
  localparam int unsigned YP_W           = 61;
  localparam int unsigned DUR_W          = 23;

  // Queue between the front and the back.
  localparam int unsigned QDEPTH         = 16;
  localparam int unsigned QPTR_W         = $clog2(QDEPTH);
  localparam int unsigned QCNT_W         = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int unsigned ADDR_W         = 3;
  localparam logic [ADDR_W-3:0] REG_SLOW_LIMIT = '0;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // One event after its timestamp has been converted to microseconds.
  typedef struct packed {
    op_e         op;
    logic [3:0]  sel;
    logic [31:0] us;
  } ldh_item_t;

  typedef struct packed {
    logic             measured;
    logic [DUR_W-1:0] duration_ms;
    logic             slow;
    logic [3:0]       bucket;
    logic [31:0]      bucket_count;
  } ldh_result_t;

  // One byte of long division by 25: returns {quotient byte, remainder}.
  function automatic logic [12:0] div25_step(input logic [4:0] rem, input logic [7:0] byte_in);
    logic [12:0] x;
    logic [23:0] p;
    logic [7:0]  q;
    logic [12:0] r;
    x = {rem, byte_in};
    p = 24'(x) * 24'(RECIP25);
    q = p[RECIP25_SHIFT +: 8];
    r = x - 13'(13'(q) * 13'(TICK_ODD));
    if (r >= 13'(TICK_ODD)) begin
      q = q + 8'd1;
      r = r - 13'(TICK_ODD);
    end
    return {q, r[4:0]};
  endfunction

endpackage

// ===== rtl/ldh_front.sv =====
// Front end: accepts events and converts the timer sample to microseconds in a byte pipeline.
module ldh_front import ldh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  op_e         op_i,
  input  logic [63:0] timer_i,
  input  logic [3:0]  sel_i,
  input  logic        pop_i,
  output logic        push_o,
  output ldh_item_t   item_o
);

  typedef struct packed {
    op_e         op;
    logic [3:0]  sel;
    logic [4:0]  rem;
    logic [31:0] quo;
    logic [63:0] num;
  } div_stage_t;

  div_stage_t            src     [DIV_STAGES];
  div_stage_t            stage_d [DIV_STAGES];
  div_stage_t            stage_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_q;
  logic [QCNT_W-1:0]     credit_d, credit_q;
  logic                  accept;

  // Credits cover the items in the pipeline and in the queue, so a push never overflows.
  assign ready_o = (credit_q < QCNT_W'(QDEPTH));
  assign accept  = valid_i && ready_o;

  always_comb begin
    logic [12:0] step;
    src[0].op  = op_i;
    src[0].sel = sel_i;
    src[0].rem = '0;
    src[0].quo = '0;
    src[0].num = 64'(timer_i >> TICK_SHIFT);
    for (int k = 1; k < DIV_STAGES; k++) begin
      src[k] = stage_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      step           = div25_step(src[k].rem, src[k].num[63:56]);
      stage_d[k]     = src[k];
      stage_d[k].rem = step[4:0];
      stage_d[k].quo = {src[k].quo[23:0], step[12:5]};
      stage_d[k].num = {src[k].num[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      stage_q[k] <= stage_d[k];
    end
  end

  assign credit_d = credit_q + QCNT_W'(accept) - QCNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      credit_q <= '0;
    end else begin
      vld_q    <= {vld_q[DIV_STAGES-2:0], accept};
      credit_q <= credit_d;
    end
  end

  assign push_o     = vld_q[DIV_STAGES-1];
  assign item_o.op  = stage_q[DIV_STAGES-1].op;
  assign item_o.sel = stage_q[DIV_STAGES-1].sel;
  assign item_o.us  = stage_q[DIV_STAGES-1].quo;

endmodule

// ===== rtl/ldh_fifo.sv =====
// Queue of converted events between the front end and the histogram back end.
module ldh_fifo import ldh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ldh_item_t item_i,
  input  logic      pop_i,
  output logic      valid_o,
  output ldh_item_t item_o
);

  ldh_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

endmodule

// ===== rtl/ldh_back.sv =====
// Back end: arming, duration, bucket selection, histogram update and the output register.
module ldh_back import ldh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  ldh_item_t   item_i,
  output logic        pop_o,
  input  logic [31:0] slow_limit_i,
  output logic        valid_o,
  input  logic        ready_i,
  output ldh_result_t result_o
);

  logic              adv;
  logic              armed_q;
  logic [31:0]       last_q;

  // Stage 1: difference against the stored time.
  logic              s1_vld_q;
  op_e               s1_op_q;
  logic [3:0]        s1_sel_q;
  logic              s1_meas_q;
  logic [31:0]       s1_diff_q;

  // Stage 2: reciprocal products.
  logic              s2_vld_q;
  op_e               s2_op_q;
  logic [3:0]        s2_sel_q;
  logic              s2_meas_q;
  logic [Y_W-1:0]    s2_y_q;
  logic [YP_W-1:0]   s2_yprod_q;
  logic              s2_sat_q;
  logic [SPAN_W-1:0] s2_x_q;
  logic [XP_W-1:0]   s2_xprod_q;

  logic              out_vld_q;
  ldh_result_t       out_d, out_q;
  logic [31:0]       hist_q [NUM_BUCKETS];

  logic [Y_W-1:0]    y_d;
  logic [DUR_W-1:0]  q_ms, dur;
  logic [Y_W-1:0]    r_ms;
  logic [BKT_W-1:0]  i0, idx, rd_idx;
  logic [SPAN_W-1:0] r_b;
  logic [31:0]       rd_val, inc_val;
  logic              sel_ok;

  // The whole back end moves together whenever the output register can take a result.
  assign adv   = !out_vld_q || ready_i;
  assign pop_o = adv && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      last_q    <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= valid_i;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
      if (valid_i) begin
        last_q <= item_i.us;
        if (item_i.op == OP_START) begin
          armed_q <= 1'b1;
        end else if (item_i.op == OP_FINISH) begin
          armed_q <= 1'b0;
        end
      end
    end
  end

  assign y_d = Y_W'((33'(s1_diff_q) + 33'(HALF_MS_US)) >> MS_SHIFT);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q    <= item_i.op;
      s1_sel_q   <= item_i.sel;
      s1_meas_q  <= (item_i.op == OP_FINISH) && armed_q;
      s1_diff_q  <= item_i.us - last_q;
      s2_op_q    <= s1_op_q;
      s2_sel_q   <= s1_sel_q;
      s2_meas_q  <= s1_meas_q;
      s2_y_q     <= y_d;
      s2_yprod_q <= YP_W'(y_d) * YP_W'(RECIP125);
      s2_sat_q   <= (s1_diff_q >= 32'(BKT_SPAN));
      s2_x_q     <= SPAN_W'(s1_diff_q);
      s2_xprod_q <= XP_W'(SPAN_W'(s1_diff_q)) * XP_W'(RECIP100);
      out_q      <= out_d;
    end
  end

  // The reciprocal estimates are exact or one short; one remainder compare fixes them.
  always_comb begin
    q_ms    = s2_yprod_q[RECIP125_SHIFT +: DUR_W];
    r_ms    = s2_y_q - Y_W'(Y_W'(q_ms) * Y_W'(MS_ODD));
    dur     = (r_ms >= Y_W'(MS_ODD)) ? q_ms + DUR_W'(1) : q_ms;
    i0      = s2_xprod_q[RECIP100_SHIFT +: BKT_W];
    r_b     = s2_x_q - SPAN_W'(SPAN_W'(i0) * SPAN_W'(US_PER_BUCKET));
    if (s2_sat_q) begin
      idx = BKT_W'(NUM_BUCKETS - 1);
    end else if (r_b >= SPAN_W'(US_PER_BUCKET)) begin
      idx = i0 + BKT_W'(1);
    end else begin
      idx = i0;
    end
    rd_idx  = s2_meas_q ? idx : BKT_W'(s2_sel_q);
    rd_val  = hist_q[rd_idx];
    inc_val = rd_val + 32'd1;
    sel_ok  = (32'(s2_sel_q) < 32'(NUM_BUCKETS));
  end

  always_comb begin
    out_d = '0;
    if (s2_meas_q) begin
      out_d.measured     = 1'b1;
      out_d.duration_ms  = dur;
      out_d.slow         = (32'(dur) > slow_limit_i);
      out_d.bucket       = 4'(idx);
      out_d.bucket_count = inc_val;
    end else if (s2_op_q == OP_READ) begin
      out_d.bucket       = s2_sel_q;
      out_d.bucket_count = sel_ok ? rd_val : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        hist_q[b] <= '0;
      end
    end else if (adv && s2_vld_q && s2_meas_q) begin
      hist_q[idx] <= inc_val;
    end
  end

  assign valid_o  = out_vld_q;
  assign result_o = out_q;

endmodule

// ===== rtl/loop_duration_histogram.sv =====
// Top level of the loop duration histogram: stream ports, register port, front, queue, back.
//
//   Channel   Direction  Transfer when            Contents
//   s_axis    in         tvalid & tready          one event: op, timer sample, bucket to read
//   m_axis    out        tvalid & tready          one result per event
//   APB       in/out     psel & penable & pwrite  slow_limit_ms at byte address 0
//
// One event is taken per cycle when the output side keeps up; the front end divides the
// timer sample by 200 in a byte-wise pipeline. The queue holds sixteen events; the input
// stalls only when the pipeline and the queue together hold sixteen. A stalled output
// freezes the back end, and the front keeps filling the queue. Reset clears the histogram,
// the arming flag and the stored time at once.
module loop_duration_histogram import ldh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [71:0]       s_axis_tdata_i,  // timer_count[63:0], read_bucket[67:64], zero fill
  input  logic [1:0]        s_axis_tuser_i,  // op[1:0]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [63:0]       m_axis_tdata_o,  // duration_ms[22:0], slow[23], bucket[27:24],
                                             // bucket_count[59:28], zero fill
  output logic [0:0]        m_axis_tuser_o,  // measured[0]
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  logic        [31:0] slow_limit_q;
  logic               push, pop, q_valid;
  ldh_item_t          push_item, q_item;
  ldh_result_t        result;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[ADDR_W-1:2] == REG_SLOW_LIMIT) ? slow_limit_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_limit_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[ADDR_W-1:2] == REG_SLOW_LIMIT) begin
      slow_limit_q <= pwdata_i;
    end
  end

  ldh_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .op_i    (op_e'(s_axis_tuser_i)),
    .timer_i (s_axis_tdata_i[63:0]),
    .sel_i   (s_axis_tdata_i[67:64]),
    .pop_i   (pop),
    .push_o  (push),
    .item_o  (push_item)
  );

  ldh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ldh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .slow_limit_i (slow_limit_q),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .result_o     (result)
  );

  assign m_axis_tdata_o = {4'b0000, result.bucket_count, result.bucket, result.slow,
                           result.duration_ms};
  assign m_axis_tuser_o = result.measured;

endmodule

// ===== rtl/ldh_checker.sv =====
// Port-level checks of the loop duration histogram, bound to the top level.
module ldh_checker import ldh_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic [71:0]       s_axis_tdata_i,
  input logic [1:0]        s_axis_tuser_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [63:0]       m_axis_tdata_o,
  input logic [0:0]        m_axis_tuser_o,
  input logic              psel_i,
  input logic              penable_i,
  input logic              pwrite_i,
  input logic [ADDR_W-1:0] paddr_i,
  input logic [31:0]       pwdata_i,
  input logic [31:0]       prdata_o,
  input logic              pready_o
);

  // A stalled result keeps its valid and its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // Without a measurement there is no duration and no slow flag.
  a_unmeasured_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[23:0] == 24'd0)
    else $error("duration or slow set without a measurement");

  // A slow run has a nonzero duration, since the limit is never negative.
  a_slow_measured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[23] |->
      m_axis_tuser_o[0] && m_axis_tdata_o[22:0] != 23'd0)
    else $error("slow flag without a nonzero measured duration");

endmodule

bind loop_duration_histogram ldh_checker u_ldh_checker (.*);

// ===== sim/loop_duration_histogram_tb.sv =====
// Self-checking testbench for the loop duration histogram: directed table, then random loops.
`timescale 1ns / 100ps

module loop_duration_histogram_tb;
  import ldh_pkg::*;

  localparam longint unsigned TICKS_PER_US  = 200;
  localparam longint unsigned ROUND_HALF_US = 500;
  localparam longint unsigned US_IN_MS      = 1000;
  localparam longint unsigned BUCKET_US     = 100;
  localparam int              SETTLE_CYCLES = 24;
  localparam int              PHASE_ITEMS   = 250;
  localparam logic [ADDR_W-1:0] LIMIT_ADDR  = {REG_SLOW_LIMIT, 2'b00};

  typedef struct packed {
    logic        measured;
    logic [22:0] dur_ms;
    logic        slow;
    logic [3:0]  bucket;
    logic [31:0] count;
  } loop_result_t;

  typedef struct {
    op_e          op;
    logic [63:0]  ticks;
    logic [3:0]   sel;
    bit           typed;
    loop_result_t want;
  } event_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [71:0]       s_axis_tdata_i;  // timer_count[63:0], read_bucket[67:64], zero fill
  logic [1:0]        s_axis_tuser_i;  // op[1:0]
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [63:0]       m_axis_tdata_o;  // duration_ms[22:0], slow[23], bucket[27:24],
                                      // bucket_count[59:28], zero fill
  logic [0:0]        m_axis_tuser_o;  // measured[0]
  logic              psel_i;
  logic              penable_i;
  logic              pwrite_i;
  logic [ADDR_W-1:0] paddr_i;
  logic [31:0]       pwdata_i;
  logic [31:0]       prdata_o;
  logic              pready_o;

  // Shadow state of the histogram.
  logic              armed_q;
  logic [31:0]       last_us_q;
  logic [31:0]       hist_q [NUM_BUCKETS];
  logic [31:0]       limit_q;

  loop_result_t      pending_results [$];
  event_row_t        directed_rows [$];
  logic [63:0]       tick_base;
  int                idle_pct;
  int                fails;

  loop_duration_histogram dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("loop_duration_histogram regression: fail");
    $finish;
  end

  function automatic loop_result_t predict_event(input op_e op, input logic [63:0] ticks,
                                                 input logic [3:0] sel);
    logic [31:0]  now_us;
    logic [31:0]  diff_us;
    logic [63:0]  slot;
    loop_result_t res;
    res    = '0;
    now_us = 32'(ticks / TICKS_PER_US);
    case (op)
      OP_START: begin
        armed_q = 1'b1;
      end
      OP_FINISH: begin
        if (armed_q) begin
          diff_us = now_us - last_us_q;
          slot    = 64'(diff_us) / BUCKET_US;
          if (slot >= 64'(NUM_BUCKETS)) slot = 64'(NUM_BUCKETS - 1);
          armed_q       = 1'b0;
          hist_q[slot]  = hist_q[slot] + 32'd1;
          res.measured  = 1'b1;
          res.dur_ms    = 23'((64'(diff_us) + ROUND_HALF_US) / US_IN_MS);
          res.slow      = (32'(res.dur_ms) > limit_q);
          res.bucket    = 4'(slot);
          res.count     = hist_q[slot];
        end
      end
      OP_READ: begin
        res.bucket = sel;
        if (32'(sel) < NUM_BUCKETS) res.count = hist_q[sel];
      end
      default: ;
    endcase
    last_us_q = now_us;
    return res;
  endfunction

  function automatic void add_row(input op_e op, input logic [63:0] ticks,
                                  input logic [3:0] sel, input bit typed = 1'b0,
                                  input loop_result_t want = '0);
    event_row_t row;
    row.op    = op;
    row.ticks = ticks;
    row.sel   = sel;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Presents one event and records its expected result once the transfer happens.
  task automatic send_event(input op_e op, input logic [63:0] ticks, input logic [3:0] sel,
                            input bit typed = 1'b0, input loop_result_t want = '0);
    loop_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, sel, ticks};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = predict_event(op, ticks, sel);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= LIMIT_ADDR;
    pwdata_i  <= value;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    limit_q = value;
    @(negedge clk_i);
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    readback = prdata_o;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    if (readback !== value) begin
      $error("slow_limit_ms readback: expected %0d, actual %0d", value, readback);
      fails++;
    end
  endtask

  task automatic run_random_phase();
    int          sent;
    int          pick;
    logic [63:0] delta;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(99) < 3) tick_base = {$urandom, $urandom};
      else tick_base = tick_base + 64'($urandom_range(400000));
      pick = $urandom_range(99);
      if (pick < 55) begin
        // A well-formed loop: start, sometimes an event in between, then finish.
        send_event(OP_START, tick_base, 4'($urandom_range(15)));
        sent++;
        if ($urandom_range(3) == 0) begin
          tick_base = tick_base + 64'($urandom_range(20000));
          send_event($urandom_range(1) ? OP_READ : OP_NONE, tick_base, 4'($urandom_range(15)));
          sent++;
        end
        if ($urandom_range(99) < 85) delta = 64'($urandom_range(1700 * 200 + 199));
        else delta = {$urandom, $urandom};
        tick_base = tick_base + delta;
        send_event(OP_FINISH, tick_base, 4'($urandom_range(15)));
        sent++;
      end else if (pick < 75) begin
        send_event(OP_READ, tick_base, 4'($urandom_range(15)));
        sent++;
      end else if (pick < 85) begin
        send_event($urandom_range(1) ? OP_NONE : OP_FINISH, tick_base,
                   4'($urandom_range(15)));
        sent++;
      end else begin
        send_event(op_e'($urandom_range(3)), {$urandom, $urandom}, 4'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    loop_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h tuser %b",
               m_axis_tdata_o, m_axis_tuser_o);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("measured", 32'(want.measured), 32'(m_axis_tuser_o[0]));
        check_field("duration_ms", 32'(want.dur_ms), 32'(m_axis_tdata_o[22:0]));
        check_field("slow", 32'(want.slow), 32'(m_axis_tdata_o[23]));
        check_field("bucket", 32'(want.bucket), 32'(m_axis_tdata_o[27:24]));
        check_field("bucket_count", want.count, m_axis_tdata_o[59:28]);
      end
    end
  end

  // Output side: random backpressure at the same rate as the input idling.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    logic [31:0] limits [5];
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_START;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = '0;
    armed_q         = 1'b0;
    last_us_q       = '0;
    limit_q         = '0;
    tick_base       = '0;
    idle_pct        = 35;
    fails           = 0;
    foreach (hist_q[i]) hist_q[i] = '0;

    // Directed part, run with the reset value of the slow limit.
    add_row(OP_READ, 64'd0, 4'd0, 1'b1, '0);
    add_row(OP_READ, 64'd0, 4'd15, 1'b1, loop_result_t'{1'b0, 23'd0, 1'b0, 4'd15, 32'd0});
    add_row(OP_FINISH, 64'd1000, 4'd0, 1'b1, '0);
    add_row(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, '0);
    add_row(OP_START, 64'd0, 4'd0, 1'b1, '0);
    add_row(OP_FINISH, 64'd199, 4'd0, 1'b1, loop_result_t'{1'b1, 23'd0, 1'b0, 4'd0, 32'd1});
    add_row(OP_START, 64'd200000, 4'd9, 1'b1, '0);
    // 1600 us lands past the last bucket and saturates.
    add_row(OP_FINISH, 64'd520000, 4'd3, 1'b1, loop_result_t'{1'b1, 23'd2, 1'b1, 4'd15, 32'd1});
    add_row(OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, '0);
    add_row(OP_FINISH, 64'd0, 4'd0);
    add_row(OP_START, 64'd0, 4'd0);
    add_row(OP_FINISH, 64'd99800, 4'd0);
    add_row(OP_START, 64'd0, 4'd0);
    add_row(OP_FINISH, 64'd100000, 4'd0);
    add_row(OP_START, 64'd0, 4'd0);
    add_row(OP_START, 64'd40000, 4'd0);
    add_row(OP_READ, 64'd60000, 4'd2);
    add_row(OP_NONE, 64'd80000, 4'd7);
    add_row(OP_FINISH, 64'd139800, 4'd0);
    add_row(OP_START, 64'd0, 4'd0);
    add_row(OP_FINISH, 64'd858993459000, 4'd0);
    add_row(OP_READ, 64'd0, 4'd15);
    add_row(OP_READ, 64'd0, 4'd5);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].op, directed_rows[i].ticks, directed_rows[i].sel,
                 directed_rows[i].typed, directed_rows[i].want);
    end
    wait_idle();

    limits[0] = 32'd1;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'd0;
    limits[3] = 32'd2;
    limits[4] = 32'($urandom_range(4294967));
    foreach (limits[p]) begin
      write_limit(limits[p]);
      // One phase runs with no idling on either side.
      idle_pct = (p == 1) ? 0 : 35;
      run_random_phase();
      wait_idle();
    end

    if (fails == 0) begin
      $display("loop_duration_histogram regression: pass");
    end else begin
      $display("loop_duration_histogram regression: fail");
    end
    $finish;
  end

endmodule
